// File: rtl/spq_pkg.sv
// Shared types and constants for the strict priority eight-queue scheduler.
// Depends on nothing; imported by the front end, back end, top level and checker.
`default_nettype none

package spq_pkg;

  // Fixed field widths.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TYPE_W   = 16;
  localparam int unsigned CLASS_W  = 8;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned GAP_W    = 16;

  // Queue count is fixed at eight.
  localparam int unsigned NUM_QUEUES = 8;
  localparam int unsigned QUEUE_W    = 3;

  // Command codes on the input channel.
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PULL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ENQ      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADCLASS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PULLED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTHING  = 3'd4;

  // Classification constants.
  localparam logic [TYPE_W-1:0]  TYPE_CLASSED = 16'h0600;
  localparam logic [CLASS_W-1:0] CLASS_MIN    = 8'd1;
  localparam logic [CLASS_W-1:0] CLASS_MAX    = 8'd8;

  // Classified operation handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_PULL,
    OP_TICK,
    OP_BAD
  } op_kind_e;

  typedef struct packed {
    op_kind_e              kind;
    logic [QUEUE_W-1:0]    queue;
    logic [HANDLE_W-1:0]   handle;
  } spq_op_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_PULL
  } back_state_e;

endpackage

`default_nettype wire

// File: rtl/spq_front.sv
// Front end: accepts input beats, classifies pushes into a target queue and
// buffers the classified operations in a two-entry queue. Depends on spq_pkg.
`default_nettype none

module spq_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [spq_pkg::CMD_W-1:0]    cmd_i,
  input  wire                          src_port_i,
  input  wire  [spq_pkg::TYPE_W-1:0]   frame_type_i,
  input  wire  [spq_pkg::CLASS_W-1:0]  class_field_i,
  input  wire  [spq_pkg::HANDLE_W-1:0] packet_handle_i,
  output logic                         op_valid_o,
  input  wire                          op_ready_i,
  output spq_pkg::spq_op_t             op_o
);
  import spq_pkg::*;

  spq_op_t     buf_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  spq_op_t     op_cls;
  logic        op_keep;
  logic        push_en;
  logic        pop_en;
  logic [CLASS_W-1:0] class_less;

  // Classify the incoming beat.
  always_comb begin
    class_less   = class_field_i - CLASS_MIN;
    op_cls       = '0;
    op_cls.kind  = OP_TICK;
    op_cls.handle = packet_handle_i;
    op_keep      = 1'b1;
    case (cmd_i)
      CMD_PUSH: begin
        op_cls.kind = OP_PUSH;
        if (!src_port_i && frame_type_i == TYPE_CLASSED) begin
          if (class_field_i < CLASS_MIN || class_field_i > CLASS_MAX) begin
            op_cls.kind = OP_BAD;
          end else begin
            op_cls.queue = class_less[QUEUE_W-1:0];
          end
        end
      end
      CMD_PULL: op_cls.kind = OP_PULL;
      CMD_TICK: op_cls.kind = OP_TICK;
      default:  op_keep = 1'b0;
    endcase
  end

  // Two-entry queue between the front and back ends.
  assign in_ready_o = (count_q != 2'd2);
  assign op_valid_o = (count_q != 2'd0);
  assign op_o       = buf_q[rd_ptr_q];
  assign push_en    = in_valid_i && in_ready_o && op_keep;
  assign pop_en     = op_valid_o && op_ready_i;

  always_comb begin
    wr_ptr_d = push_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_en ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_en} - {1'b0, pop_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      buf_q[wr_ptr_q] <= op_cls;
    end
  end

endmodule

`default_nettype wire

// File: rtl/spq_back.sv
// Back end: executes classified operations against the queue storage, keeps
// pointers, fill counts, the gap timer and the output register. Depends on spq_pkg.
`default_nettype none

module spq_back #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [spq_pkg::GAP_W-1:0]     cfg_wdata_i,
  input  wire                           op_valid_i,
  output logic                          op_ready_o,
  input  spq_pkg::spq_op_t              op_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [spq_pkg::STATUS_W-1:0]  status_o,
  output logic [spq_pkg::HANDLE_W-1:0]  out_handle_o,
  output logic [spq_pkg::QUEUE_W-1:0]   out_queue_o
);
  import spq_pkg::*;

  localparam int unsigned PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W   = QUEUE_W + PTR_W;
  localparam int unsigned MEM_SIZE = 2 ** ADDR_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [HANDLE_W-1:0] mem [MEM_SIZE];
  logic [HANDLE_W-1:0] rd_data_q;

  logic [PTR_W-1:0] head_q [NUM_QUEUES];
  logic [PTR_W-1:0] head_d [NUM_QUEUES];
  logic [PTR_W-1:0] tail_q [NUM_QUEUES];
  logic [PTR_W-1:0] tail_d [NUM_QUEUES];
  logic [CNT_W-1:0] fill_q [NUM_QUEUES];
  logic [CNT_W-1:0] fill_d [NUM_QUEUES];

  logic [GAP_W-1:0] gap_q, gap_d;
  logic [GAP_W-1:0] ticks_q, ticks_d;
  back_state_e      state_q, state_d;
  logic [QUEUE_W-1:0] pull_q_q, pull_q_d;

  logic               out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [QUEUE_W-1:0]  queue_q, queue_d;
  logic               out_load;

  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [QUEUE_W-1:0] sel_queue;
  logic               sel_found;
  logic               refused;

  // Free to start an operation when idle and the output slot is free or draining.
  assign op_ready_o = (state_q == BK_IDLE) && (!out_valid_q || out_ready_i);

  // Lowest-numbered non-empty queue.
  always_comb begin
    sel_queue = '0;
    sel_found = 1'b0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (fill_q[i] != '0) begin
        sel_queue = QUEUE_W'(i);
        sel_found = 1'b1;
      end
    end
  end

  assign refused = (gap_q != '0) && (ticks_q < gap_q);

  // Operation sequencer.
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    ticks_d  = ticks_q;
    gap_d    = cfg_we_i ? cfg_wdata_i : gap_q;
    state_d  = state_q;
    pull_q_d = pull_q_q;
    out_load = 1'b0;
    status_d = status_q;
    handle_d = handle_q;
    queue_d  = queue_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = {op_i.queue, tail_q[op_i.queue]};
    rd_addr  = {sel_queue, head_q[sel_queue]};

    case (state_q)
      BK_IDLE: begin
        if (op_valid_i && op_ready_o) begin
          case (op_i.kind)
            OP_PUSH: begin
              out_load = 1'b1;
              handle_d = '0;
              queue_d  = op_i.queue;
              if (fill_q[op_i.queue] == CNT_FULL) begin
                status_d = ST_FULL;
              end else begin
                status_d = ST_ENQ;
                wr_en    = 1'b1;
                tail_d[op_i.queue] = (tail_q[op_i.queue] == PTR_LAST) ? '0 :
                                     tail_q[op_i.queue] + 1'b1;
                fill_d[op_i.queue] = fill_q[op_i.queue] + 1'b1;
              end
            end
            OP_BAD: begin
              out_load = 1'b1;
              status_d = ST_BADCLASS;
              handle_d = '0;
              queue_d  = '0;
            end
            OP_TICK: begin
              if (ticks_q != '1) begin
                ticks_d = ticks_q + 1'b1;
              end
            end
            OP_PULL: begin
              if (refused) begin
                out_load = 1'b1;
                status_d = ST_NOTHING;
                handle_d = '0;
                queue_d  = '0;
              end else begin
                ticks_d = '0;
                if (sel_found) begin
                  rd_en    = 1'b1;
                  pull_q_d = sel_queue;
                  state_d  = BK_PULL;
                  head_d[sel_queue] = (head_q[sel_queue] == PTR_LAST) ? '0 :
                                      head_q[sel_queue] + 1'b1;
                  fill_d[sel_queue] = fill_q[sel_queue] - 1'b1;
                end else begin
                  out_load = 1'b1;
                  status_d = ST_NOTHING;
                  handle_d = '0;
                  queue_d  = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      BK_PULL: begin
        // Read data of the head entry is now registered.
        out_load = 1'b1;
        status_d = ST_PULLED;
        handle_d = rd_data_q;
        queue_d  = pull_q_q;
        state_d  = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
      gap_q       <= '0;
      ticks_q     <= '0;
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      gap_q       <= gap_d;
      ticks_q     <= ticks_d;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pull_q_q <= pull_q_d;
    status_q <= status_d;
    handle_q <= handle_d;
    queue_q  <= queue_d;
  end

  // Queue storage with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= op_i.handle;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_handle_o = handle_q;
  assign out_queue_o  = queue_q;

endmodule

`default_nettype wire

// File: rtl/strict_priority_eight_queue_scheduler_unit.sv
// A push, bad-class push or refused/empty pull passes the operation buffer and result
// register; a served pull also passes the registered read of the queue storage.
// Throughput: one push or tick per cycle while the result output is not stalled; no new
// operation is taken while a served pull reads. Ticks and command 3 give no result.
// Reset (async, active low) clears pointers, fill counts, timer, gap register and
// the operation buffer; the queue storage is not cleared and needs no clearing pass.
`default_nettype none

module strict_priority_eight_queue_scheduler_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [spq_pkg::GAP_W-1:0]     cfg_wdata_i,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  [spq_pkg::CMD_W-1:0]     cmd_i,
  input  wire                           src_port_i,
  input  wire  [spq_pkg::TYPE_W-1:0]    frame_type_i,
  input  wire  [spq_pkg::CLASS_W-1:0]   class_field_i,
  input  wire  [spq_pkg::HANDLE_W-1:0]  packet_handle_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [spq_pkg::STATUS_W-1:0]  status_o,
  output logic [spq_pkg::HANDLE_W-1:0]  out_handle_o,
  output logic [spq_pkg::QUEUE_W-1:0]   out_queue_o
);
  import spq_pkg::*;

  spq_op_t op;
  logic    op_valid;
  logic    op_ready;

  // Classification and buffering.
  spq_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .src_port_i      (src_port_i),
    .frame_type_i    (frame_type_i),
    .class_field_i   (class_field_i),
    .packet_handle_i (packet_handle_i),
    .op_valid_o      (op_valid),
    .op_ready_i      (op_ready),
    .op_o            (op)
  );

  // Queue execution and result output.
  spq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .op_valid_i   (op_valid),
    .op_ready_o   (op_ready),
    .op_i         (op),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .out_handle_o (out_handle_o),
    .out_queue_o  (out_queue_o)
  );

endmodule

`default_nettype wire

// File: rtl/spq_checker.sv
// Port-level checker for the scheduler top level, bound to it below.
// Depends on spq_pkg and strict_priority_eight_queue_scheduler_unit.
`default_nettype none

module spq_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           out_valid_o,
  input wire                           out_ready_i,
  input wire [spq_pkg::STATUS_W-1:0]   status_o,
  input wire [spq_pkg::HANDLE_W-1:0]   out_handle_o,
  input wire [spq_pkg::QUEUE_W-1:0]    out_queue_o
);
  import spq_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(out_handle_o) && $stable(out_queue_o))
    else $error("result beat changed while stalled");

  // Only a served pull carries a handle.
  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_PULLED |-> out_handle_o == '0)
    else $error("handle set on a result that is not a pull");

  // Bad class and nothing results name no queue.
  a_queue_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_BADCLASS || status_o == ST_NOTHING)
    |-> out_queue_o == '0)
    else $error("queue set on a result that uses no queue");

endmodule

bind strict_priority_eight_queue_scheduler_unit spq_checker u_spq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .out_handle_o (out_handle_o),
  .out_queue_o  (out_queue_o)
);

`default_nettype wire

// File: bench/strict_priority_eight_queue_scheduler_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the strict priority eight-queue scheduler: directed table, then random
// push, pull and tick traffic under several gap settings. Depends on spq_pkg and the top level.

module strict_priority_eight_queue_scheduler_unit_test;
  import spq_pkg::*;

  localparam int unsigned QUEUE_SLOTS   = 16;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned PHASE_BEATS   = 140;
  localparam int unsigned PRINT_CAP     = 40;
  // Command 3 has no meaning; the block must swallow it silently.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic                port;
    logic [TYPE_W-1:0]   ftype;
    logic [CLASS_W-1:0]  cls;
    logic [HANDLE_W-1:0] handle;
  } beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
    logic [QUEUE_W-1:0]  queue;
  } answer_t;

  typedef struct packed {
    beat_t   beat;
    logic    typed;
    answer_t want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [GAP_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd;
  logic                src_port;
  logic [TYPE_W-1:0]   frame_type;
  logic [CLASS_W-1:0]  class_field;
  logic [HANDLE_W-1:0] packet_handle;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] out_handle;
  logic [QUEUE_W-1:0]  out_queue;

  // Shadow copy of the scheduler state.
  logic [HANDLE_W-1:0] model_store [NUM_QUEUES][QUEUE_SLOTS];
  int unsigned         model_head [NUM_QUEUES];
  int unsigned         model_tail [NUM_QUEUES];
  int unsigned         model_fill [NUM_QUEUES];
  logic [GAP_W-1:0]    model_timer;
  logic [GAP_W-1:0]    model_gap;

  answer_t     awaited_answers [$];
  row_t        directed_rows [];
  bit          sender_calm;
  int unsigned beats_sent;
  int unsigned answers_checked;
  int unsigned mismatch_count;
  int unsigned n_enq, n_badclass, n_full, n_served, n_idle_pulls;

  strict_priority_eight_queue_scheduler_unit #(
    .QUEUE_DEPTH(QUEUE_SLOTS)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .src_port_i     (src_port),
    .frame_type_i   (frame_type),
    .class_field_i  (class_field),
    .packet_handle_i(packet_handle),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .out_handle_o   (out_handle),
    .out_queue_o    (out_queue)
  );

  // Free-running clock, 8 ns period.
  always #4 clk = ~clk;

  // Predict one accepted beat: update the shadow state and return the answer, if any.
  task automatic advance_scheduler(input beat_t b, output bit produced, output answer_t r);
    int unsigned q;
    bit bad;
    bit found;
    produced = 1'b0;
    r = '0;
    q = 0;
    bad = 1'b0;
    found = 1'b0;
    case (b.cmd)
      CMD_PUSH: begin
        produced = 1'b1;
        // Only classed frames on the query port pick a queue by class.
        if (!b.port && b.ftype == TYPE_CLASSED) begin
          if (b.cls < CLASS_MIN || b.cls > CLASS_MAX) bad = 1'b1;
          else q = b.cls - 1;
        end
        if (bad) begin
          r.status = ST_BADCLASS;
          n_badclass++;
        end else if (model_fill[q] >= QUEUE_SLOTS) begin
          r.status = ST_FULL;
          r.queue  = QUEUE_W'(q);
          n_full++;
        end else begin
          model_store[q][model_tail[q]] = b.handle;
          model_tail[q] = (model_tail[q] + 1 >= QUEUE_SLOTS) ? 0 : model_tail[q] + 1;
          model_fill[q]++;
          r.status = ST_ENQ;
          r.queue  = QUEUE_W'(q);
          n_enq++;
        end
      end
      CMD_PULL: begin
        produced = 1'b1;
        r.status = ST_NOTHING;
        if (model_gap != 0 && model_timer < model_gap) begin
          n_idle_pulls++;
        end else begin
          // An allowed pull restarts the gap timer even when nothing is queued.
          model_timer = '0;
          for (int i = 0; i < NUM_QUEUES && !found; i++) begin
            if (model_fill[i] != 0) begin
              found    = 1'b1;
              r.status = ST_PULLED;
              r.handle = model_store[i][model_head[i]];
              r.queue  = QUEUE_W'(i);
              model_head[i] = (model_head[i] + 1 >= QUEUE_SLOTS) ? 0 : model_head[i] + 1;
              model_fill[i]--;
            end
          end
          if (found) n_served++;
          else n_idle_pulls++;
        end
      end
      CMD_TICK: begin
        if (model_timer != '1) model_timer++;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t ns] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic row_t dir_row(input logic [CMD_W-1:0] c, input logic p,
                                   input logic [TYPE_W-1:0] t, input logic [CLASS_W-1:0] k,
                                   input logic [HANDLE_W-1:0] h, input logic typed,
                                   input logic [STATUS_W-1:0] st, input logic [HANDLE_W-1:0] wh,
                                   input logic [QUEUE_W-1:0] wq);
    row_t r;
    r.beat  = '{cmd: c, port: p, ftype: t, cls: k, handle: h};
    r.typed = typed;
    r.want  = '{status: st, handle: wh, queue: wq};
    return r;
  endfunction

  // Well-formed push of a classed frame on the query port.
  function automatic beat_t classed_push(input logic [CLASS_W-1:0] k);
    beat_t b;
    b.cmd    = CMD_PUSH;
    b.port   = 1'b0;
    b.ftype  = TYPE_CLASSED;
    b.cls    = k;
    b.handle = HANDLE_W'($urandom);
    return b;
  endfunction

  // Pull or tick; the other fields carry random content the block must ignore.
  function automatic beat_t ctl_beat(input logic [CMD_W-1:0] c);
    beat_t b;
    b        = beat_t'({$urandom, $urandom});
    b.cmd    = c;
    return b;
  endfunction

  // Anything at all, with the classed type often enough to hit bad classes.
  function automatic beat_t noise_beat();
    beat_t b;
    b = beat_t'({$urandom, $urandom});
    if ($urandom_range(0, 1) == 0) b.ftype = TYPE_CLASSED;
    return b;
  endfunction

  // Offer one beat after a random gap and predict it once it is taken.
  task automatic send_beat(input beat_t b, input bit typed, input answer_t typed_answer);
    int unsigned gap;
    bit produced;
    answer_t answer;
    gap = sender_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= b.cmd;
    src_port      <= b.port;
    frame_type    <= b.ftype;
    class_field   <= b.cls;
    packet_handle <= b.handle;
    do @(posedge clk); while (!in_ready);
    advance_scheduler(b, produced, answer);
    if (produced) awaited_answers.push_back(typed ? typed_answer : answer);
    if (b.cmd != CMD_UNUSED) beats_sent++;
  endtask

  // Stop offering, wait for every awaited answer, then let trailing ticks settle.
  task automatic drain_answers();
    in_valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gap(input logic [GAP_W-1:0] v);
    drain_answers();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_gap = v;
  endtask

  // One random stretch of traffic shaped like real queue use.
  task automatic run_segment();
    int unsigned kind;
    int unsigned len;
    int unsigned lead;
    logic [CLASS_W-1:0] k;
    bit via_port1;
    beat_t b;
    sender_calm = ($urandom_range(0, 4) == 0);
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      // Burst into one queue, long enough to overflow it at times.
      len = $urandom_range(1, 20);
      k = CLASS_W'($urandom_range(1, 8));
      via_port1 = ($urandom_range(0, 3) == 0);
      repeat (len) begin
        b = classed_push(k);
        if (via_port1) begin
          b.port  = 1'b1;
          b.ftype = TYPE_W'($urandom);
        end
        send_beat(b, 1'b0, '0);
      end
    end else if (kind <= 4) begin
      // Pull burst, each pull often led by a random run of ticks up to one past the gap.
      len = $urandom_range(1, 12);
      repeat (len) begin
        lead = (model_gap == 0 || $urandom_range(0, 3) == 0) ? 0
             : $urandom_range(0, int'(model_gap) + 1);
        repeat (lead) send_beat(ctl_beat(CMD_TICK), 1'b0, '0);
        send_beat(ctl_beat(CMD_PULL), 1'b0, '0);
      end
    end else if (kind <= 7) begin
      len = $urandom_range(1, 16);
      repeat (len) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: b = classed_push(CLASS_W'($urandom_range(1, 8)));
          4, 5, 6:    b = ctl_beat(CMD_PULL);
          7, 8:       b = ctl_beat(CMD_TICK);
          default:    b = noise_beat();
        endcase
        send_beat(b, 1'b0, '0);
      end
    end else begin
      len = $urandom_range(1, 6);
      repeat (len) send_beat(noise_beat(), 1'b0, '0);
    end
  endtask

  // Result side: random back-pressure, each beat checked against the oldest prediction.
  initial begin : answer_sink
    int unsigned stall;
    bit eager;
    answer_t want;
    eager = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 29) == 0) eager = !eager;
      stall = eager ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (awaited_answers.size() == 0) begin
        report_mismatch("status of an answer nobody awaited", status, 0);
      end else begin
        want = awaited_answers.pop_front();
        answers_checked++;
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (out_handle !== want.handle) report_mismatch("out_handle", out_handle, want.handle);
        if (out_queue !== want.queue) report_mismatch("out_queue", out_queue, want.queue);
      end
    end
  end

  // Stimulus: reset, directed table, random phases per gap, then the widest gap.
  initial begin : stimulus
    logic [GAP_W-1:0] gap_plan [6];
    logic [GAP_W-1:0] phase_gap;
    int unsigned phase_end;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    cmd           <= CMD_PUSH;
    src_port      <= 1'b0;
    frame_type    <= '0;
    class_field   <= '0;
    packet_handle <= '0;
    out_ready     <= 1'b0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      model_head[i] = 0;
      model_tail[i] = 0;
      model_fill[i] = 0;
    end
    model_timer = '0;
    model_gap   = '0;
    sender_calm = 1'b0;
    beats_sent = 0;
    answers_checked = 0;
    mismatch_count = 0;
    n_enq = 0;
    n_badclass = 0;
    n_full = 0;
    n_served = 0;
    n_idle_pulls = 0;
    gap_plan = '{16'd1, 16'd0, 16'd4, 16'd2, 16'd0, 16'd0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Rows with typed answers are obvious from the rules; the rest go to the predictor.
    directed_rows = '{
      dir_row(CMD_PULL,   1'b0, 16'h0000, 8'd0,   16'h0000, 1'b1, ST_NOTHING,  16'h0, 3'd0),
      dir_row(CMD_PUSH,   1'b0, 16'h0600, 8'd0,   16'h1111, 1'b1, ST_BADCLASS, 16'h0, 3'd0),
      dir_row(CMD_PUSH,   1'b0, 16'h0600, 8'd9,   16'h2222, 1'b1, ST_BADCLASS, 16'h0, 3'd0),
      dir_row(CMD_PUSH,   1'b0, 16'h0600, 8'hFF,  16'h3333, 1'b1, ST_BADCLASS, 16'h0, 3'd0),
      dir_row(CMD_PUSH,   1'b0, 16'h0600, 8'd8,   16'hFFFF, 1'b1, ST_ENQ,      16'h0, 3'd7),
      dir_row(CMD_PUSH,   1'b0, 16'h0600, 8'd1,   16'h0000, 1'b1, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PUSH,   1'b1, 16'h0600, 8'd5,   16'h1234, 1'b1, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PUSH,   1'b0, 16'h0601, 8'd3,   16'hABCD, 1'b1, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PUSH,   1'b0, 16'h0000, 8'd0,   16'h5555, 1'b1, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PUSH,   1'b1, 16'hFFFF, 8'hFF,  16'hAAAA, 1'b1, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PUSH,   1'b0, 16'h0600, 8'd4,   16'h00FF, 1'b1, ST_ENQ,      16'h0, 3'd3),
      dir_row(CMD_UNUSED, 1'b1, 16'hFFFF, 8'hFF,  16'hFFFF, 1'b0, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_TICK,   1'b0, 16'h0600, 8'd2,   16'h7777, 1'b0, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PULL,   1'b0, 16'h0000, 8'd0,   16'h0000, 1'b0, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PULL,   1'b1, 16'hFFFF, 8'hFF,  16'hFFFF, 1'b0, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PULL,   1'b0, 16'h0600, 8'd1,   16'h0000, 1'b0, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PULL,   1'b0, 16'h0000, 8'd0,   16'h0000, 1'b0, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PULL,   1'b0, 16'h0000, 8'd0,   16'h0000, 1'b0, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PULL,   1'b0, 16'h0000, 8'd0,   16'h0000, 1'b0, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PULL,   1'b0, 16'h0000, 8'd0,   16'h0000, 1'b0, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PULL,   1'b0, 16'h0000, 8'd0,   16'h0000, 1'b0, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PUSH,   1'b0, 16'h0600, 8'd2,   16'h8000, 1'b0, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_TICK,   1'b0, 16'h0000, 8'd0,   16'h0000, 1'b0, ST_ENQ,      16'h0, 3'd0),
      dir_row(CMD_PULL,   1'b0, 16'h0000, 8'd0,   16'h0000, 1'b0, ST_ENQ,      16'h0, 3'd0)
    };
    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

    // Random phases, each under its own gap setting.
    for (int p = 0; p < 6; p++) begin
      phase_gap = (p == 4) ? GAP_W'($urandom_range(5, 12)) : gap_plan[p];
      write_gap(phase_gap);
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) run_segment();
    end

    // Widest gap: the timer stays far below it here, so every pull until the gap is written back to zero is refused.
    send_beat(ctl_beat(CMD_PULL), 1'b0, '0);
    write_gap(16'hFFFF);
    repeat (3) send_beat(classed_push(CLASS_W'($urandom_range(1, 8))), 1'b0, '0);
    send_beat(ctl_beat(CMD_PULL), 1'b0, '0);
    sender_calm = 1'b0;
    repeat (8) send_beat(ctl_beat(CMD_TICK), 1'b0, '0);
    send_beat(ctl_beat(CMD_PULL), 1'b0, '0);
    send_beat(ctl_beat(CMD_PULL), 1'b0, '0);
    write_gap(16'd0);
    repeat (20) send_beat(ctl_beat(CMD_PULL), 1'b0, '0);

    drain_answers();
    $display("Covered %0d beats and %0d checked answers over gaps 0 to 65535.",
             beats_sent, answers_checked);
    $display("Enqueued %0d, bad class %0d, full %0d, served %0d, refused or empty %0d.",
             n_enq, n_badclass, n_full, n_served, n_idle_pulls);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #40_000_000;
    $display("Timeout with %0d answers still awaited.", awaited_answers.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
